// File: rtl/core/vng_pkg.sv
`timescale 1ns / 1ps

package vng_pkg;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_ACCUM_WIDTH  = 48;

  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int EDGE_W  = 17;
  localparam int PROD_W  = 34;
  localparam int CROSS_W = 35;
  localparam int NORM_W  = 16;
  localparam int RANGE_W = 17;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TRIANGLE = 2'd1,
    CMD_READ     = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     command;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic [IDX_W-1:0]         index_c;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     zero_length;
  } out_item_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] x;
    logic signed [EDGE_W-1:0] y;
    logic signed [EDGE_W-1:0] z;
  } edge_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } cross_t;

  typedef struct packed {
    logic start;
    logic ack;
  } norm_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POS_B,
    ST_POS_C,
    ST_POS_W,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_NORM_RD,
    ST_NORM
  } ctrl_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_MAX,
    N_SHIFT,
    N_SQUARE,
    N_ROOT,
    N_DLOAD,
    N_DIV,
    N_DONE
  } norm_state_t;

endpackage

// File: rtl/core/vng_cross.sv
`timescale 1ns / 1ps

module vng_cross import vng_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  edge_t  eb,
  input  edge_t  ec,
  output cross_t n,
  output logic   done
);

  logic                      busy;
  logic [2:0]                cnt;
  logic signed [EDGE_W-1:0]  op_a;
  logic signed [EDGE_W-1:0]  op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_hold;
  logic [CROSS_W-1:0]        diff;

  // pick the operand pair for this step, two steps per component
  always_comb begin
    case (cnt)
      3'd0:    begin op_a = eb.y; op_b = ec.z; end
      3'd1:    begin op_a = eb.z; op_b = ec.y; end
      3'd2:    begin op_a = eb.z; op_b = ec.x; end
      3'd3:    begin op_a = eb.x; op_b = ec.z; end
      3'd4:    begin op_a = eb.x; op_b = ec.y; end
      default: begin op_a = eb.y; op_b = ec.x; end
    endcase
  end

  assign prod = op_a * op_b;
  assign diff = {prod_hold[PROD_W-1], prod_hold} - {prod[PROD_W-1], prod};

  // step the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // hold the first product, finish a component on the second
  always_ff @(posedge clk) begin
    if (busy) begin
      if (!cnt[0]) begin
        prod_hold <= prod;
      end else begin
        case (cnt)
          3'd1:    n.x <= diff;
          3'd3:    n.y <= diff;
          default: n.z <= diff;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/vng_norm.sv
`timescale 1ns / 1ps

module vng_norm import vng_pkg::*; #(
  parameter int ACCUM_WIDTH = DEF_ACCUM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  norm_req_t                     req,
  input  logic signed [ACCUM_WIDTH-1:0] vec_x,
  input  logic signed [ACCUM_WIDTH-1:0] vec_y,
  input  logic signed [ACCUM_WIDTH-1:0] vec_z,
  output logic                          done,
  output out_item_t                     result
);

  localparam int MAG_W  = 30;
  localparam int SQ_W   = 60;
  localparam int ROOT_W = 62;
  localparam int LEN_W  = 32;
  localparam int DIV_W  = 48;
  localparam int Q_W    = 17;

  localparam logic [ACCUM_WIDTH-1:0] TOP_LIM = ACCUM_WIDTH'(1) << 30;
  localparam logic [ACCUM_WIDTH-1:0] LOW_LIM = ACCUM_WIDTH'(1) << 29;

  norm_state_t              state;
  norm_state_t              state_next;
  logic [ACCUM_WIDTH-1:0]   mag [3];
  logic [2:0]               neg;
  logic [ACCUM_WIDTH-1:0]   m;
  logic [ACCUM_WIDTH-1:0]   m_max;
  logic [ROOT_W-1:0]        sum;
  logic [ROOT_W-1:0]        rem;
  logic [ROOT_W-1:0]        res;
  logic [ROOT_W-1:0]        rbit;
  logic [ROOT_W-1:0]        trial;
  logic [1:0]               idx;
  logic [DIV_W-1:0]         dl_rem;
  logic [DIV_W-1:0]         dl_d;
  logic [Q_W-1:0]           q;
  logic [Q_W-1:0]           q_next;
  logic [4:0]               step;
  logic [ACCUM_WIDTH-1:0]   cur_mag;
  logic                     cur_neg;
  logic [SQ_W-1:0]          sq;
  logic [NORM_W-1:0]        comp;

  // select the component in work
  always_comb begin
    case (idx)
      2'd0:    begin cur_mag = mag[0]; cur_neg = neg[0]; end
      2'd1:    begin cur_mag = mag[1]; cur_neg = neg[1]; end
      default: begin cur_mag = mag[2]; cur_neg = neg[2]; end
    endcase
  end

  always_comb begin
    m_max = mag[0];
    if (mag[1] > m_max) m_max = mag[1];
    if (mag[2] > m_max) m_max = mag[2];
  end

  assign sq     = cur_mag[MAG_W-1:0] * cur_mag[MAG_W-1:0];
  assign trial  = res + rbit;
  assign q_next = {q[Q_W-2:0], (dl_rem >= dl_d)};

  // round-to-nearest quotient into Q1.15 with saturation
  always_comb begin
    if (cur_neg) begin
      comp = (q_next > Q_W'(32768)) ? 16'h8000 : (~q_next[NORM_W-1:0] + 16'd1);
    end else begin
      comp = (q_next > Q_W'(32767)) ? 16'h7FFF : q_next[NORM_W-1:0];
    end
  end

  assign done = (state == N_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advance the sequence: find the largest, shift, square, root, divide; a zero vector goes straight to done
  always_comb begin
    state_next = state;
    case (state)
      N_IDLE:   if (req.start) state_next = N_MAX;
      N_MAX:    state_next = (m_max == '0) ? N_DONE : N_SHIFT;
      N_SHIFT:  if (m < TOP_LIM && m >= LOW_LIM) state_next = N_SQUARE;
      N_SQUARE: if (idx == 2'd2) state_next = N_ROOT;
      N_ROOT:   if (rbit == ROOT_W'(1)) state_next = N_DLOAD;
      N_DLOAD:  state_next = N_DIV;
      N_DIV:    if (step == 5'd16) state_next = (idx == 2'd2) ? N_DONE : N_DLOAD;
      N_DONE:   if (req.ack) state_next = N_IDLE;
      default:  state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        mag[0] <= vec_x[ACCUM_WIDTH-1] ? (ACCUM_WIDTH'(0) - vec_x) : vec_x;
        mag[1] <= vec_y[ACCUM_WIDTH-1] ? (ACCUM_WIDTH'(0) - vec_y) : vec_y;
        mag[2] <= vec_z[ACCUM_WIDTH-1] ? (ACCUM_WIDTH'(0) - vec_z) : vec_z;
        neg    <= {vec_z[ACCUM_WIDTH-1], vec_y[ACCUM_WIDTH-1], vec_x[ACCUM_WIDTH-1]};
      end
      N_MAX: begin
        m      <= m_max;
        result <= out_item_t'({{(3*NORM_W){1'b0}}, (m_max == '0)});
      end
      N_SHIFT: begin
        sum <= '0;
        idx <= '0;
        if (m >= TOP_LIM) begin
          m      <= m >> 1;
          mag[0] <= mag[0] >> 1;
          mag[1] <= mag[1] >> 1;
          mag[2] <= mag[2] >> 1;
        end else if (m < LOW_LIM) begin
          m      <= m << 1;
          mag[0] <= mag[0] << 1;
          mag[1] <= mag[1] << 1;
          mag[2] <= mag[2] << 1;
        end
      end
      N_SQUARE: begin
        sum <= sum + ROOT_W'(sq);
        idx <= idx + 2'd1;
        rem  <= sum + ROOT_W'(sq);
        res  <= '0;
        rbit <= ROOT_W'(1) << 60;
      end
      N_ROOT: begin
        idx <= '0;
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
      end
      N_DLOAD: begin
        dl_rem <= (DIV_W'(cur_mag[MAG_W-1:0]) << 15) + DIV_W'(res[LEN_W-1:1]);
        dl_d   <= DIV_W'(res[LEN_W-1:0]) << 16;
        q      <= '0;
        step   <= '0;
      end
      N_DIV: begin
        if (dl_rem >= dl_d) dl_rem <= dl_rem - dl_d;
        dl_d <= dl_d >> 1;
        q    <= q_next;
        step <= step + 5'd1;
        if (step == 5'd16) begin
          idx <= idx + 2'd1;
          case (idx)
            2'd0:    result.normal_x <= comp;
            2'd1:    result.normal_y <= comp;
            default: result.normal_z <= comp;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/vertex_normal_generator_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        into core  in_valid / in_stall  in_item  (in_item_t)
// out       from core  out_valid/out_stall  out_item (out_item_t)
// cfg       into core  cfg_valid/cfg_ready  cfg_data (smooth_mode)
//
// Write position: done in the idle state. Triangle: three position reads, six
// steps of the one cross-product multiplier and an update of each accumulator
// row, a read-modify-write in smooth mode and a plain write in flat mode.
// Read: a zero vector skips the rest of the normaliser, otherwise it runs
// up to 29 scaling shifts, a 31-step square root and three 17-step divides.
// Clear: one accumulator row a cycle; reset runs the same clearing pass, so
// in_stall stays high after reset until every row is cleared.
// A result waits in the output register under out_stall; the core stalls only
// once a second result is ready.

module vertex_normal_generator_core import vng_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int ACCUM_WIDTH  = DEF_ACCUM_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int ADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int ROW_W   = 3 * ACCUM_WIDTH;
  localparam int POSR_W  = 3 * POS_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VERTICES - 1);

  ctrl_state_t               state;
  ctrl_state_t               state_next;
  logic                      smooth;
  logic [ADDR_W-1:0]         ia;
  logic [ADDR_W-1:0]         ib;
  logic [ADDR_W-1:0]         ic;
  logic                      a_ok;
  logic [POSR_W-1:0]         pos_a;
  edge_t                     eb;
  edge_t                     ec;
  logic [1:0]                kk;
  logic [ADDR_W-1:0]         clr_cnt;
  logic [ADDR_W-1:0]         cur_addr;

  logic [POSR_W-1:0]         pos_mem [MAX_VERTICES];
  logic                      pos_we;
  logic                      pos_re;
  logic [ADDR_W-1:0]         pos_raddr;
  logic [POSR_W-1:0]         pos_rdata;

  logic [ROW_W-1:0]          acc_mem [MAX_VERTICES];
  logic                      acc_we;
  logic                      acc_re;
  logic [ADDR_W-1:0]         acc_waddr;
  logic [ROW_W-1:0]          acc_wdata;
  logic [ROW_W-1:0]          acc_rdata;
  logic [ROW_W-1:0]          upd_row;

  logic                      in_take;
  logic                      tri_ok;
  logic                      cross_start;
  logic                      cross_done;
  cross_t                    n;
  norm_req_t                 norm_req;
  logic                      norm_done;
  out_item_t                 norm_result;
  logic signed [ACCUM_WIDTH-1:0] nv_x;
  logic signed [ACCUM_WIDTH-1:0] nv_y;
  logic signed [ACCUM_WIDTH-1:0] nv_z;
  logic                      out_load;

  function automatic logic idx_ok(logic [IDX_W-1:0] i);
    return {{(RANGE_W-IDX_W){1'b0}}, i} < RANGE_W'(MAX_VERTICES);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(logic [IDX_W-1:0] i);
    logic [RANGE_W-1:0] ext;
    ext = {{(RANGE_W-IDX_W){1'b0}}, i};
    return ext[ADDR_W-1:0];
  endfunction

  function automatic logic [ACCUM_WIDTH-1:0] sext_cross(logic [CROSS_W-1:0] b);
    return {{(ACCUM_WIDTH-CROSS_W){b[CROSS_W-1]}}, b};
  endfunction

  function automatic logic [ACCUM_WIDTH-1:0] sat_add(logic [ACCUM_WIDTH-1:0] a,
                                                     logic [CROSS_W-1:0] b);
    logic [ACCUM_WIDTH:0] s;
    s = {a[ACCUM_WIDTH-1], a} + {{(ACCUM_WIDTH+1-CROSS_W){b[CROSS_W-1]}}, b};
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      return s[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                            : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    end
    return s[ACCUM_WIDTH-1:0];
  endfunction

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign tri_ok    = idx_ok(in_item.index_a) && idx_ok(in_item.index_b)
                     && idx_ok(in_item.index_c);

  // vertex of the current accumulator update
  always_comb begin
    case (kk)
      2'd0:    cur_addr = ia;
      2'd1:    cur_addr = ib;
      default: cur_addr = ic;
    endcase
  end

  // new accumulator row: add with saturation, or overwrite
  always_comb begin
    if (smooth) begin
      upd_row = {sat_add(acc_rdata[ROW_W-1 -: ACCUM_WIDTH], n.x),
                 sat_add(acc_rdata[2*ACCUM_WIDTH-1 -: ACCUM_WIDTH], n.y),
                 sat_add(acc_rdata[ACCUM_WIDTH-1:0], n.z)};
    end else begin
      upd_row = {sext_cross(n.x), sext_cross(n.y), sext_cross(n.z)};
    end
  end

  // feed the normaliser; an out-of-range read gives the zero vector
  assign nv_x = a_ok ? acc_rdata[ROW_W-1 -: ACCUM_WIDTH] : '0;
  assign nv_y = a_ok ? acc_rdata[2*ACCUM_WIDTH-1 -: ACCUM_WIDTH] : '0;
  assign nv_z = a_ok ? acc_rdata[ACCUM_WIDTH-1:0] : '0;

  // sequence each command through the two memories
  always_comb begin
    state_next  = state;
    pos_we      = 1'b0;
    pos_re      = 1'b0;
    pos_raddr   = ib;
    acc_we      = 1'b0;
    acc_re      = 1'b0;
    acc_waddr   = cur_addr;
    acc_wdata   = upd_row;
    cross_start = 1'b0;
    norm_req    = '0;
    out_load    = 1'b0;
    case (state)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_cnt;
        acc_wdata = '0;
        if (clr_cnt == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_take) begin
          case (in_item.command)
            CMD_WRITE: pos_we = idx_ok(in_item.index_a);
            CMD_TRIANGLE: begin
              if (tri_ok) begin
                pos_re     = 1'b1;
                pos_raddr  = to_addr(in_item.index_a);
                state_next = ST_POS_B;
              end
            end
            CMD_READ: begin
              acc_re     = 1'b1;
              state_next = ST_NORM_RD;
            end
            CMD_CLEAR: state_next = ST_CLEAR;
            default: ;
          endcase
        end
      end
      ST_POS_B: begin
        pos_re     = 1'b1;
        pos_raddr  = ib;
        state_next = ST_POS_C;
      end
      ST_POS_C: begin
        pos_re     = 1'b1;
        pos_raddr  = ic;
        state_next = ST_POS_W;
      end
      ST_POS_W: begin
        cross_start = 1'b1;
        state_next  = ST_CROSS;
      end
      ST_CROSS: begin
        if (cross_done) state_next = smooth ? ST_ACC_RD : ST_ACC_WR;
      end
      ST_ACC_RD: begin
        acc_re     = 1'b1;
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        acc_we = 1'b1;
        if (kk == 2'd2) begin
          state_next = ST_IDLE;
        end else begin
          state_next = smooth ? ST_ACC_RD : ST_ACC_WR;
        end
      end
      ST_NORM_RD: begin
        norm_req.start = 1'b1;
        state_next     = ST_NORM;
      end
      ST_NORM: begin
        if (norm_done && (!out_valid || !out_stall)) begin
          out_load     = 1'b1;
          norm_req.ack = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      smooth  <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= (state == ST_CLEAR) ? clr_cnt + ADDR_W'(1) : '0;
      if (cfg_valid) smooth <= cfg_data;
    end
  end

  // hold command operands and triangle edges
  always_ff @(posedge clk) begin
    if (in_take) begin
      ia   <= to_addr(in_item.index_a);
      ib   <= to_addr(in_item.index_b);
      ic   <= to_addr(in_item.index_c);
      a_ok <= idx_ok(in_item.index_a);
    end
    if (state == ST_POS_B) pos_a <= pos_rdata;
    if (state == ST_POS_C) begin
      eb <= {{pos_rdata[47], pos_rdata[47:32]} - {pos_a[47], pos_a[47:32]},
             {pos_rdata[31], pos_rdata[31:16]} - {pos_a[31], pos_a[31:16]},
             {pos_rdata[15], pos_rdata[15:0]}  - {pos_a[15], pos_a[15:0]}};
    end
    if (state == ST_POS_W) begin
      ec <= {{pos_rdata[47], pos_rdata[47:32]} - {pos_a[47], pos_a[47:32]},
             {pos_rdata[31], pos_rdata[31:16]} - {pos_a[31], pos_a[31:16]},
             {pos_rdata[15], pos_rdata[15:0]}  - {pos_a[15], pos_a[15:0]}};
    end
    if (state == ST_CROSS) begin
      kk <= '0;
    end else if (state == ST_ACC_WR) begin
      kk <= kk + 2'd1;
    end
  end

  // position memory
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[to_addr(in_item.index_a)] <= {in_item.pos_x, in_item.pos_y, in_item.pos_z};
    end
    if (pos_re) pos_rdata <= pos_mem[pos_raddr];
  end

  // accumulator memory; read address is the held target except on a new read
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (acc_re) begin
      acc_rdata <= acc_mem[(state == ST_IDLE) ? to_addr(in_item.index_a) : cur_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_item <= norm_result;
  end

  vng_cross u_cross (
    .clk   (clk),
    .rst   (rst),
    .start (cross_start),
    .eb    (eb),
    .ec    (ec),
    .n     (n),
    .done  (cross_done)
  );

  vng_norm #(
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_norm (
    .clk    (clk),
    .rst    (rst),
    .req    (norm_req),
    .vec_x  (nv_x),
    .vec_y  (nv_y),
    .vec_z  (nv_z),
    .done   (norm_done),
    .result (norm_result)
  );

endmodule

// File: rtl/core/vng_checker.sv
`timescale 1ns / 1ps

module vng_checker import vng_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // a zero vector reports all-zero components
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.zero_length |->
      out_item.normal_x == 16'sd0 && out_item.normal_y == 16'sd0 &&
      out_item.normal_z == 16'sd0)
    else $error("zero-length result with non-zero components");

  // a unit vector always has a non-zero component
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.zero_length |->
      out_item.normal_x != 16'sd0 || out_item.normal_y != 16'sd0 ||
      out_item.normal_z != 16'sd0)
    else $error("normalised result is all zero");

  // the clearing pass holds off input after reset
  a_reset_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken straight after reset");

endmodule

bind vertex_normal_generator_core vng_checker u_vng_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import vng_pkg::*;

  localparam int NV          = DEF_MAX_VERTICES;
  localparam int DRAIN_WAIT  = 1200;   // clearing pass plus a triangle
  localparam int STUCK_LIMIT = 20000;

  // Per-vertex normal predictor and the queue of normals still owed
  class normal_board;
    bit          smooth;
    int          px[NV], py[NV], pz[NV];
    longint      ax[NV], ay[NV], az[NV];
    out_item_t   owed[$];
    int          errors;

    function new();
      smooth = 0;
      errors = 0;
      foreach (ax[i]) begin
        ax[i] = 0; ay[i] = 0; az[i] = 0;
        px[i] = 0; py[i] = 0; pz[i] = 0;
      end
    endfunction

    function longint sat48(longint a, longint b);
      longint hi, lo, s;
      hi = (longint'(1) <<< 47) - 1;
      lo = -hi - 1;
      s = a + b;
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return s;
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned rem, res, bt;
      rem = x; res = 0; bt = 64'd1 << 62;
      while (bt > rem) bt = bt >> 2;
      while (bt != 0) begin
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function out_item_t unit_normal(longint vx, longint vy, longint vz);
      longint          v[3];
      longint unsigned mag[3], m, sum, len, q;
      bit              neg[3];
      logic [15:0]     r[3];
      out_item_t       o;
      v[0] = vx; v[1] = vy; v[2] = vz;
      m = 0; sum = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? longint'(-v[i]) : v[i];
        if (mag[i] > m) m = mag[i];
      end
      o = '0;
      if (m == 0) begin
        o.zero_length = 1'b1;
        return o;
      end
      // scale the largest into [2^29, 2^30)
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 32768 + len / 2) / len;
        if (neg[i]) begin
          if (q > 32768) q = 32768;
          r[i] = 16'(-longint'(q));
        end else begin
          if (q > 32767) q = 32767;
          r[i] = 16'(q);
        end
      end
      o.normal_x = r[0]; o.normal_y = r[1]; o.normal_z = r[2];
      return o;
    endfunction

    function void note(in_item_t it);
      longint abx, aby, abz, acx, acy, acz, nx, ny, nz;
      int     ids[3];
      case (it.command)
        CMD_WRITE: begin
          px[it.index_a] = int'(it.pos_x);
          py[it.index_a] = int'(it.pos_y);
          pz[it.index_a] = int'(it.pos_z);
        end
        CMD_TRIANGLE: begin
          abx = px[it.index_b] - px[it.index_a];
          aby = py[it.index_b] - py[it.index_a];
          abz = pz[it.index_b] - pz[it.index_a];
          acx = px[it.index_c] - px[it.index_a];
          acy = py[it.index_c] - py[it.index_a];
          acz = pz[it.index_c] - pz[it.index_a];
          nx = aby * acz - abz * acy;
          ny = abz * acx - abx * acz;
          nz = abx * acy - aby * acx;
          ids[0] = int'(it.index_a); ids[1] = int'(it.index_b); ids[2] = int'(it.index_c);
          // update A, B then C, so in smooth mode a repeated vertex gets the product twice
          for (int k = 0; k < 3; k++) begin
            if (smooth) begin
              ax[ids[k]] = sat48(ax[ids[k]], nx);
              ay[ids[k]] = sat48(ay[ids[k]], ny);
              az[ids[k]] = sat48(az[ids[k]], nz);
            end else begin
              ax[ids[k]] = nx; ay[ids[k]] = ny; az[ids[k]] = nz;
            end
          end
        end
        CMD_READ:
          owed = {owed, unit_normal(ax[it.index_a], ay[it.index_a], az[it.index_a])};
        default: begin
          foreach (ax[i]) begin
            ax[i] = 0; ay[i] = 0; az[i] = 0;
          end
        end
      endcase
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected normal %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.normal_x !== want.normal_x) begin
        $display("%0t: normal_x expected %0d got %0d", $time, want.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== want.normal_y) begin
        $display("%0t: normal_y expected %0d got %0d", $time, want.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== want.normal_z) begin
        $display("%0t: normal_z expected %0d got %0d", $time, want.normal_z, got.normal_z);
        errors++;
      end
      if (got.zero_length !== want.zero_length) begin
        $display("%0t: zero_length expected %0b got %0b", $time, want.zero_length,
                 got.zero_length);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  normal_board board = new();
  bit          calm = 1'b0;
  bit          placed[NV];
  int          placed_ids[$];
  int          stuck = 0;

  always #2 clk = ~clk;

  vertex_normal_generator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check(out_item);
  end

  // Random back-pressure on the result side
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 8);
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
    board.note(it);
    if (it.command == CMD_WRITE && !placed[it.index_a]) begin
      placed[it.index_a] = 1'b1;
      placed_ids = {placed_ids, int'(it.index_a)};
    end
    @(negedge clk);
  endtask

  // Drain, let a pending clear or triangle finish, then set the mode
  task automatic set_mode(bit m);
    in_valid = 1'b0;
    wait (board.owed.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    do @(posedge clk); while (!cfg_ready);
    board.smooth = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t noise();
    in_item_t    it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t mk(cmd_t c, int a, int b, int cc,
                                  int x = 0, int y = 0, int z = 0);
    in_item_t it;
    it = noise();
    it.command = c;
    it.index_a = IDX_W'(a); it.index_b = IDX_W'(b); it.index_c = IDX_W'(cc);
    it.pos_x = POS_W'(x); it.pos_y = POS_W'(y); it.pos_z = POS_W'(z);
    return it;
  endfunction

  function automatic int pick_placed();
    return placed_ids[$urandom_range(placed_ids.size() - 1)];
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       r;
    it = noise();
    r = $urandom_range(99);
    if (r < 20 || placed_ids.size() < 3) begin
      it.command = CMD_WRITE;
      if ($urandom_range(1)) it.index_a = IDX_W'($urandom_range(63));
      if ($urandom_range(2) == 0) begin
        it.pos_x = POS_W'($signed($urandom_range(512)) - 256);
        it.pos_y = POS_W'($signed($urandom_range(512)) - 256);
        it.pos_z = POS_W'($signed($urandom_range(512)) - 256);
      end
    end else if (r < 62) begin
      it.command = CMD_TRIANGLE;
      it.index_a = IDX_W'(pick_placed());
      it.index_b = IDX_W'(pick_placed());
      it.index_c = IDX_W'(pick_placed());
    end else if (r < 98) begin
      it.command = CMD_READ;
      if ($urandom_range(3) != 0) it.index_a = IDX_W'(pick_placed());
    end else begin
      it.command = CMD_CLEAR;
    end
    return it;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: flat mode, extreme coordinates, degenerate and repeated vertices
    set_mode(1'b0);
    send(mk(CMD_READ, 1023, 0, 0));
    send(mk(CMD_WRITE, 0, 0, 0, 32767, -32768, 0));
    send(mk(CMD_WRITE, 1, 0, 0, -32768, 32767, 32767));
    send(mk(CMD_WRITE, 1023, 0, 0, -32768, -32768, -32768));
    send(mk(CMD_WRITE, 2, 0, 0, 256, 0, 0));
    send(mk(CMD_WRITE, 3, 0, 0, 0, 256, 0));
    send(mk(CMD_WRITE, 4, 0, 0, 0, 0, 1));
    send(mk(CMD_TRIANGLE, 0, 1, 1023));
    send(mk(CMD_READ, 0, 0, 0));
    send(mk(CMD_READ, 1023, 0, 0));
    send(mk(CMD_TRIANGLE, 4, 2, 3));
    send(mk(CMD_READ, 2, 0, 0));
    send(mk(CMD_TRIANGLE, 2, 2, 3));
    send(mk(CMD_READ, 2, 0, 0));
    send(mk(CMD_READ, 5, 0, 0));

    // Smooth mode: shared vertices accumulate, a repeated vertex twice
    set_mode(1'b1);
    send(mk(CMD_TRIANGLE, 4, 2, 3));
    send(mk(CMD_TRIANGLE, 4, 3, 4));
    send(mk(CMD_TRIANGLE, 0, 1, 1023));
    send(mk(CMD_READ, 4, 0, 0));
    send(mk(CMD_READ, 0, 0, 0));
    send(mk(CMD_CLEAR, 0, 0, 0));
    send(mk(CMD_READ, 4, 0, 0));

    // Random phases across both modes
    for (int ph = 0; ph < 3; ph++) begin
      set_mode(ph != 1);
      for (int n = 0; n < 235; n++) begin
        calm = (ph == 1 && n >= 60 && n < 180);
        send(rand_item());
      end
      calm = 1'b0;
    end
    in_valid = 1'b0;

    wait (board.owed.size() == 0);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
